@@ src/led_matrix_column_scanner_core_defines.svh @@
// ----------------------------------------------------------------------------
// LED matrix column scanner assertion macros
// Concurrent assertion wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_COLUMN_SCANNER_CORE_DEFINES_SVH
`define LED_MATRIX_COLUMN_SCANNER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define LMCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LMCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LMCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LMCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ src/lmcs_pkg.sv @@
// ----------------------------------------------------------------------------
// lmcs_pkg
// Shared types, constants and the column effect function.
// ----------------------------------------------------------------------------
package lmcs_pkg;

  localparam int COLUMNS_DEF   = 24;
  localparam int LEVEL_MAX_DEF = 32;

  localparam int PIX_W  = 8;
  localparam int EFF_W  = 4;
  localparam int COL_W  = 5;
  localparam int LVL_W  = 6;

  localparam int EFF_BLINK     = 0;
  localparam int EFF_INVERT    = 1;
  localparam int EFF_UNDERLINE = 2;
  localparam int EFF_FAST      = 3;

  localparam logic [2:0] KIND_BLINK_ONLY = 3'b001;
  localparam logic [PIX_W-1:0] UNDERLINE_MASK = 8'h80;
  localparam logic [PIX_W-1:0] INVERT_MASK    = 8'hff;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_SWAP  = 2'd2,
    CMD_LEVEL = 2'd3
  } cmd_t;

  typedef struct packed {
    logic rd_en;
    logic rd_bank;
    logic wr_en;
    logic wr_bank;
  } store_ctl_t;

  function automatic logic [PIX_W-1:0] column_effect(
    input logic [PIX_W-1:0] value,
    input logic [EFF_W-1:0] eff,
    input logic             slow,
    input logic             fast
  );
    logic [2:0]       kind;
    logic             phase;
    logic [PIX_W-1:0] res;
    kind  = eff[2:0];
    phase = eff[EFF_FAST] ? fast : slow;
    res   = value;
    if (kind[EFF_BLINK] && !phase) begin
      res = value;
    end else if (kind == KIND_BLINK_ONLY) begin
      res = '0;
    end else begin
      if (kind[EFF_UNDERLINE]) res = res | UNDERLINE_MASK;
      if (kind[EFF_INVERT])    res = res ^ INVERT_MASK;
    end
    return res;
  endfunction

endpackage

@@ src/led_matrix_column_scanner_core.sv @@
// ----------------------------------------------------------------------------
// led_matrix_column_scanner_core
// Column-multiplexed LED matrix scanner with PWM dimming, double-buffered
// picture and per-column blink/invert/underline effects.
//
//   channel | handshake             | fields
//   --------+-----------------------+------------------------------------------------------
//   in      | in_valid / in_ready   | cmd column pixels effect level slow_toggle fast_toggle
//   out     | out_valid / out_ready | row_drive active_column column_lit swap_pending
//
// One transaction per cycle sustained while the output is not stalled; each result passes
// the first stage (scan state update, pixel memory read), then the second (effect).
// Reset clears scan state, bank select, both memories (by valid bits) and
// sets brightness to half of LEVEL_MAX. A stalled output holds the second
// stage; input stalls only while both stages are full.
// ----------------------------------------------------------------------------
`include "led_matrix_column_scanner_core_defines.svh"

module led_matrix_column_scanner_core
  import lmcs_pkg::*;
#(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int LEVEL_MAX = LEVEL_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_cmd,
  input  logic [COL_W-1:0] in_column,
  input  logic [PIX_W-1:0] in_pixels,
  input  logic [EFF_W-1:0] in_effect,
  input  logic [LVL_W-1:0] in_level,
  input  logic             in_slow_toggle,
  input  logic             in_fast_toggle,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_row_drive,
  output logic [COL_W-1:0] out_active_column,
  output logic             out_column_lit,
  output logic             out_swap_pending
);

  localparam int CW = $clog2(COLUMNS);
  localparam int TW = $clog2(LEVEL_MAX + 2);
  localparam int BW = $clog2(LEVEL_MAX + 1);
  localparam logic [COL_W+1:0] COL_LIM = (COL_W + 2)'(COLUMNS);

  logic [TW-1:0] tick_r, tick_nxt;
  logic [BW-1:0] bright_r, bright_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic          front_r, front_nxt;
  logic          swap_r, swap_nxt;
  logic          lit_r, lit_nxt;
  logic [PIX_W-1:0] row_r, row_nxt;

  logic          s1_valid_r;
  logic          s1_load_r, s1_dark_r, s1_slow_r, s1_fast_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_lit_r, s1_swap_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_row_r;
  logic [CW-1:0]    out_col_r;
  logic             out_lit_r, out_swap_r;

  logic             accept, advance, s1_fire;
  logic             load, dark;
  logic [LVL_W-1:0] lvl_sat;
  store_ctl_t       ctl;
  logic [PIX_W-1:0] rd_pixels;
  logic [EFF_W-1:0] rd_effect;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign accept   = in_valid && in_ready;
  assign s1_fire  = s1_valid_r && advance;

  always_comb begin
    if (in_level == '0) begin
      lvl_sat = LVL_W'(1);
    end else if (in_level > LVL_W'(LEVEL_MAX)) begin
      lvl_sat = LVL_W'(LEVEL_MAX);
    end else begin
      lvl_sat = in_level;
    end
  end

  always_comb begin
    tick_nxt   = tick_r;
    bright_nxt = bright_r;
    scan_nxt   = scan_r;
    front_nxt  = front_r;
    swap_nxt   = swap_r;
    lit_nxt    = lit_r;
    load       = 1'b0;
    dark       = 1'b0;
    ctl        = '0;
    ctl.rd_bank = front_r;
    ctl.wr_bank = ~front_r;
    if (accept) begin
      unique case (cmd_t'(in_cmd))
        CMD_TICK: begin
          if (tick_r == '0) begin
            load      = 1'b1;
            lit_nxt   = 1'b1;
            ctl.rd_en = 1'b1;
            tick_nxt  = tick_r + TW'(1);
          end else if (tick_r == TW'(bright_r)) begin
            dark     = 1'b1;
            lit_nxt  = 1'b0;
            tick_nxt = tick_r + TW'(1);
          end else if (tick_r >= TW'(LEVEL_MAX)) begin
            tick_nxt = '0;
            if (scan_r == CW'(COLUMNS - 1)) begin
              scan_nxt = '0;
              if (swap_r) begin
                front_nxt = ~front_r;
                swap_nxt  = 1'b0;
              end
            end else begin
              scan_nxt = scan_r + CW'(1);
            end
          end else begin
            tick_nxt = tick_r + TW'(1);
          end
        end
        CMD_WRITE: begin
          if ({2'b00, in_column} < COL_LIM) ctl.wr_en = 1'b1;
        end
        CMD_SWAP: begin
          swap_nxt = 1'b1;
        end
        CMD_LEVEL: begin
          if (tick_r < TW'(lvl_sat)) bright_nxt = BW'(lvl_sat);
        end
        default: begin
        end
      endcase
    end
  end

  lmcs_store #(
    .COLUMNS (COLUMNS),
    .CW      (CW)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .rd_col    (scan_r),
    .wr_col    (CW'(in_column)),
    .wr_pixels (in_pixels),
    .wr_effect (in_effect),
    .rd_pixels (rd_pixels),
    .rd_effect (rd_effect)
  );

  always_comb begin
    if (s1_load_r) begin
      row_nxt = column_effect(rd_pixels, rd_effect, s1_slow_r, s1_fast_r);
    end else if (s1_dark_r) begin
      row_nxt = '0;
    end else begin
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      bright_r    <= BW'(LEVEL_MAX >> 1);
      scan_r      <= '0;
      front_r     <= 1'b0;
      swap_r      <= 1'b0;
      lit_r       <= 1'b0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tick_r   <= tick_nxt;
      bright_r <= bright_nxt;
      scan_r   <= scan_nxt;
      front_r  <= front_nxt;
      swap_r   <= swap_nxt;
      lit_r    <= lit_nxt;
      if (in_ready) s1_valid_r <= in_valid;
      if (s1_fire) row_r <= row_nxt;
      if (advance) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_load_r <= load;
      s1_dark_r <= dark;
      s1_slow_r <= in_slow_toggle;
      s1_fast_r <= in_fast_toggle;
      s1_col_r  <= scan_nxt;
      s1_lit_r  <= lit_nxt;
      s1_swap_r <= swap_nxt;
    end
    if (s1_fire) begin
      out_row_r  <= row_nxt;
      out_col_r  <= s1_col_r;
      out_lit_r  <= s1_lit_r;
      out_swap_r <= s1_swap_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row_drive     = out_row_r;
  assign out_active_column = COL_W'(out_col_r);
  assign out_column_lit    = out_lit_r;
  assign out_swap_pending  = out_swap_r;

  `LMCS_ASSERT_IMP(a_tick_range, clk, rst_n, 1'b1, tick_r <= TW'(LEVEL_MAX + 1),
                   "tick count out of range")
  `LMCS_ASSERT_IMP(a_bright_range, clk, rst_n, 1'b1,
                   (bright_r != '0) && (bright_r <= BW'(LEVEL_MAX)), "brightness out of range")
  `LMCS_ASSERT_IMP(a_dark_rows, clk, rst_n, out_valid_r && !out_lit_r, out_row_r == '0,
                   "rows driven while column dark")
  `LMCS_ASSERT_IMP(a_stall_only, clk, rst_n, !in_ready,
                   s1_valid_r && out_valid_r && !out_ready,
                   "input stalled without output backpressure")
  `LMCS_ASSERT_NXT(a_swap_frame, clk, rst_n,
                   accept && (cmd_t'(in_cmd) == CMD_TICK) && (tick_r >= TW'(LEVEL_MAX)) &&
                   (tick_r != '0) && (tick_r != TW'(bright_r)) &&
                   (scan_r == CW'(COLUMNS - 1)) && swap_r,
                   (front_r != $past(front_r)) && !swap_r, "bank swap missed at frame end")

endmodule

@@ src/lmcs_store.sv @@
// ----------------------------------------------------------------------------
// lmcs_store
// Double-banked pixel memory and single-banked effect memory, synchronous
// read, entries read as zero until first written.
// ----------------------------------------------------------------------------
module lmcs_store
  import lmcs_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int CW      = $clog2(COLUMNS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  store_ctl_t       ctl,
  input  logic [CW-1:0]    rd_col,
  input  logic [CW-1:0]    wr_col,
  input  logic [PIX_W-1:0] wr_pixels,
  input  logic [EFF_W-1:0] wr_effect,
  output logic [PIX_W-1:0] rd_pixels,
  output logic [EFF_W-1:0] rd_effect
);

  localparam int PDEPTH = 2 * COLUMNS;
  localparam int PAW    = $clog2(PDEPTH);

  logic [PIX_W-1:0]  pix_mem [PDEPTH];
  logic [EFF_W-1:0]  eff_mem [COLUMNS];
  logic [PDEPTH-1:0] pix_vld_r;
  logic [COLUMNS-1:0] eff_vld_r;

  logic [PAW-1:0]   rd_paddr;
  logic [PAW-1:0]   wr_paddr;
  logic [PIX_W-1:0] pix_q_r;
  logic [EFF_W-1:0] eff_q_r;
  logic             pix_qv_r;
  logic             eff_qv_r;

  assign rd_paddr = ctl.rd_bank ? PAW'(rd_col) + PAW'(COLUMNS) : PAW'(rd_col);
  assign wr_paddr = ctl.wr_bank ? PAW'(wr_col) + PAW'(COLUMNS) : PAW'(wr_col);

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      pix_mem[wr_paddr] <= wr_pixels;
      eff_mem[wr_col]   <= wr_effect;
    end
    if (ctl.rd_en) begin
      pix_q_r  <= pix_mem[rd_paddr];
      eff_q_r  <= eff_mem[rd_col];
      pix_qv_r <= pix_vld_r[rd_paddr];
      eff_qv_r <= eff_vld_r[rd_col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_vld_r <= '0;
      eff_vld_r <= '0;
    end else if (ctl.wr_en) begin
      pix_vld_r[wr_paddr] <= 1'b1;
      eff_vld_r[wr_col]   <= 1'b1;
    end
  end

  assign rd_pixels = pix_qv_r ? pix_q_r : '0;
  assign rd_effect = eff_qv_r ? eff_q_r : '0;

endmodule

@@ bench/led_matrix_column_scanner_core_tb.sv @@
// ----------------------------------------------------------------------------
// led_matrix_column_scanner_core_tb
// Self-checking bench for the column scanner. A queue of scan commands feeds a
// valid/ready driver. Each accepted transaction steps a local model of the
// scan, the picture banks and the effects. A monitor compares every result
// transaction with the oldest predicted frame. Both sides idle at random.
// ----------------------------------------------------------------------------
module led_matrix_column_scanner_core_tb
  import lmcs_pkg::*;
;

  localparam int NCOLS       = COLUMNS_DEF;
  localparam int LVL_TOP     = LEVEL_MAX_DEF;
  localparam int RANDOM_CMDS = 930;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    cmd_t             cmd;
    logic [COL_W-1:0] column;
    logic [PIX_W-1:0] pixels;
    logic [EFF_W-1:0] effect;
    logic [LVL_W-1:0] level;
    logic             slow;
    logic             fast;
  } scan_cmd_t;

  typedef struct {
    logic [PIX_W-1:0] rows;
    logic [COL_W-1:0] column;
    logic             lit;
    logic             swap;
  } frame_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_cmd = '0;
  logic [COL_W-1:0] in_column = '0;
  logic [PIX_W-1:0] in_pixels = '0;
  logic [EFF_W-1:0] in_effect = '0;
  logic [LVL_W-1:0] in_level = '0;
  logic             in_slow_toggle = 1'b0;
  logic             in_fast_toggle = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [PIX_W-1:0] out_row_drive;
  logic [COL_W-1:0] out_active_column;
  logic             out_column_lit;
  logic             out_swap_pending;

  led_matrix_column_scanner_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_column        (in_column),
    .in_pixels        (in_pixels),
    .in_effect        (in_effect),
    .in_level         (in_level),
    .in_slow_toggle   (in_slow_toggle),
    .in_fast_toggle   (in_fast_toggle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_row_drive    (out_row_drive),
    .out_active_column(out_active_column),
    .out_column_lit   (out_column_lit),
    .out_swap_pending (out_swap_pending)
  );

  always #1 clk = ~clk;

  // local copy of the scanner state
  logic [PIX_W-1:0] pic_mem [2*NCOLS];
  logic [EFF_W-1:0] fx_mem [NCOLS];
  logic             shown_bank;
  logic             swap_req;
  logic [COL_W-1:0] scan_col;
  logic [LVL_W-1:0] tick_cnt;
  logic [LVL_W-1:0] on_time;
  logic [PIX_W-1:0] row_q;
  logic             lit_q;

  scan_cmd_t pending_cmds[$];
  frame_t    expected_frames[$];
  scan_cmd_t cur_cmd;
  frame_t    want;
  int        errors = 0;
  int        frames_seen = 0;
  int        send_gap = 0;
  int        recv_gap = 0;
  int        send_quiet = 0;
  int        recv_quiet = 0;
  int        idle_cycles = 0;

  function automatic logic [PIX_W-1:0] shade_column(
    input logic [PIX_W-1:0] value,
    input logic [EFF_W-1:0] eff,
    input logic             slow,
    input logic             fast
  );
    logic             phase;
    logic [PIX_W-1:0] shade;
    phase = eff[EFF_FAST] ? fast : slow;
    shade = value;
    if (eff[EFF_BLINK] && !phase) return shade;
    if (eff[EFF_BLINK] && !eff[EFF_INVERT] && !eff[EFF_UNDERLINE]) return '0;
    if (eff[EFF_UNDERLINE]) shade = shade | UNDERLINE_MASK;
    if (eff[EFF_INVERT]) shade = shade ^ INVERT_MASK;
    return shade;
  endfunction

  function automatic void reset_scanner();
    foreach (pic_mem[i]) pic_mem[i] = '0;
    foreach (fx_mem[i]) fx_mem[i] = '0;
    shown_bank = 1'b0;
    swap_req   = 1'b0;
    scan_col   = '0;
    tick_cnt   = '0;
    on_time    = LVL_W'(LVL_TOP >> 1);
    row_q      = '0;
    lit_q      = 1'b0;
  endfunction

  function automatic frame_t scanner_step(input scan_cmd_t c);
    frame_t f;
    int     lv;
    int     col;
    case (c.cmd)
      CMD_TICK: begin
        if (tick_cnt == 0) begin
          col   = scan_col % NCOLS;
          row_q = shade_column(pic_mem[shown_bank*NCOLS + col], fx_mem[col], c.slow, c.fast);
          lit_q = 1'b1;
          tick_cnt = tick_cnt + 1'b1;
        end else if (tick_cnt == on_time) begin
          row_q = '0;
          lit_q = 1'b0;
          tick_cnt = tick_cnt + 1'b1;
        end else if (tick_cnt >= LVL_TOP) begin
          if (scan_col + 1 >= NCOLS) begin
            if (swap_req) begin
              shown_bank = ~shown_bank;
              swap_req   = 1'b0;
            end
            scan_col = '0;
          end else begin
            scan_col = scan_col + 1'b1;
          end
          tick_cnt = '0;
        end else begin
          tick_cnt = tick_cnt + 1'b1;
        end
      end
      CMD_WRITE: begin
        if (c.column < NCOLS) begin
          pic_mem[(!shown_bank)*NCOLS + c.column] = c.pixels;
          fx_mem[c.column] = c.effect;
        end
      end
      CMD_SWAP: swap_req = 1'b1;
      default: begin
        lv = int'(c.level);
        if (lv < 1) lv = 1;
        if (lv > LVL_TOP) lv = LVL_TOP;
        if (tick_cnt < lv) on_time = LVL_W'(lv);
      end
    endcase
    f.rows   = row_q;
    f.column = scan_col;
    f.lit    = lit_q;
    f.swap   = swap_req;
    return f;
  endfunction

  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_cmd(
    input cmd_t             cmd,
    input logic [COL_W-1:0] column,
    input logic [PIX_W-1:0] pixels,
    input logic [EFF_W-1:0] effect,
    input logic [LVL_W-1:0] level,
    input logic             slow,
    input logic             fast
  );
    scan_cmd_t c;
    c.cmd = cmd;
    c.column = column;
    c.pixels = pixels;
    c.effect = effect;
    c.level = level;
    c.slow = slow;
    c.fast = fast;
    pending_cmds.push_back(c);
  endfunction

  task automatic report_mismatch(input string field, input int got, input int exp_val);
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
             frames_seen, field, got, exp_val);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_frames.push_back(scanner_step(cur_cmd));
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        in_valid       <= 1'b1;
        in_cmd         <= cur_cmd.cmd;
        in_column      <= cur_cmd.column;
        in_pixels      <= cur_cmd.pixels;
        in_effect      <= cur_cmd.effect;
        in_level       <= cur_cmd.level;
        in_slow_toggle <= cur_cmd.slow;
        in_fast_toggle <= cur_cmd.fast;
        send_gap = pick_gap(send_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("unexpected transaction", int'(out_row_drive), 0);
        end else begin
          want = expected_frames.pop_front();
          if (out_row_drive !== want.rows)
            report_mismatch("row_drive", int'(out_row_drive), int'(want.rows));
          if (out_active_column !== want.column)
            report_mismatch("active_column", int'(out_active_column), int'(want.column));
          if (out_column_lit !== want.lit)
            report_mismatch("column_lit", int'(out_column_lit), int'(want.lit));
          if (out_swap_pending !== want.swap)
            report_mismatch("swap_pending", int'(out_swap_pending), int'(want.swap));
        end
        frames_seen++;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) recv_gap = pick_gap(recv_quiet);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  initial begin
    int r;
    cmd_t             cmd;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] px;
    logic [EFF_W-1:0] fx;
    logic [LVL_W-1:0] lvl;
    logic             sl;
    logic             fs;
    reset_scanner();

    // directed: brightness clamps and refusal, effects, bank writes, swaps
    queue_cmd(CMD_LEVEL, 5'd0, 8'h00, 4'h0, 6'd0, 1'b0, 1'b0);
    queue_cmd(CMD_TICK, 5'd0, 8'h00, 4'h0, 6'd0, 1'b1, 1'b1);
    queue_cmd(CMD_TICK, 5'd0, 8'h00, 4'h0, 6'd0, 1'b0, 1'b0);
    queue_cmd(CMD_LEVEL, 5'd31, 8'hff, 4'hf, 6'd1, 1'b1, 1'b1);
    queue_cmd(CMD_LEVEL, 5'd0, 8'h00, 4'h0, 6'd63, 1'b0, 1'b0);
    queue_cmd(CMD_LEVEL, 5'd0, 8'h00, 4'h0, 6'd32, 1'b0, 1'b1);
    queue_cmd(CMD_WRITE, 5'd0, 8'hff, 4'hf, 6'd0, 1'b0, 1'b0);
    queue_cmd(CMD_WRITE, 5'd23, 8'h00, 4'h6, 6'd0, 1'b1, 1'b0);
    queue_cmd(CMD_WRITE, 5'd24, 8'h5a, 4'hf, 6'd63, 1'b0, 1'b0);
    queue_cmd(CMD_WRITE, 5'd31, 8'ha5, 4'h1, 6'd0, 1'b1, 1'b1);
    queue_cmd(CMD_WRITE, 5'd1, 8'h01, 4'h1, 6'd0, 1'b0, 1'b0);
    queue_cmd(CMD_WRITE, 5'd2, 8'h7e, 4'hd, 6'd0, 1'b0, 1'b1);
    queue_cmd(CMD_WRITE, 5'd16, 8'h80, 4'h4, 6'd0, 1'b0, 1'b0);
    queue_cmd(CMD_WRITE, 5'd3, 8'h33, 4'h3, 6'd0, 1'b0, 1'b0);
    queue_cmd(CMD_SWAP, 5'd0, 8'h00, 4'h0, 6'd0, 1'b0, 1'b0);
    queue_cmd(CMD_SWAP, 5'd31, 8'hff, 4'hf, 6'd63, 1'b1, 1'b1);
    queue_cmd(CMD_TICK, 5'd0, 8'h00, 4'h0, 6'd0, 1'b0, 1'b1);
    queue_cmd(CMD_TICK, 5'd0, 8'h00, 4'h0, 6'd0, 1'b1, 1'b0);
    queue_cmd(CMD_TICK, 5'd31, 8'hff, 4'hf, 6'd63, 1'b1, 1'b1);
    queue_cmd(CMD_LEVEL, 5'd0, 8'h00, 4'h0, 6'd33, 1'b0, 1'b0);
    queue_cmd(CMD_TICK, 5'd0, 8'h00, 4'h0, 6'd0, 1'b0, 1'b0);

    // random: mostly ticks so the scan crosses a frame boundary
    repeat (RANDOM_CMDS) begin
      r   = $urandom_range(0, 99);
      col = COL_W'($urandom_range(0, 31));
      px  = PIX_W'($urandom_range(0, 255));
      fx  = EFF_W'($urandom_range(0, 15));
      lvl = LVL_W'($urandom_range(0, 63));
      sl  = 1'($urandom_range(0, 1));
      fs  = 1'($urandom_range(0, 1));
      if (r < 86) begin
        cmd = CMD_TICK;
      end else if (r < 94) begin
        cmd = CMD_WRITE;
        if ($urandom_range(0, 9) != 0) col = COL_W'($urandom_range(0, NCOLS-1));
      end else if (r < 97) begin
        cmd = CMD_SWAP;
      end else begin
        cmd = CMD_LEVEL;
      end
      queue_cmd(cmd, col, px, fx, lvl, sl, fs);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
